// File: src/ashs_pkg.sv
// ----------------------------------------------------------------------------
// ashs_pkg
// Shared constants and helpers for the soft/hard saturator: register map,
// reset values, fixed-point constants and the Q60 multiply used to build the
// tanh table at elaboration.
// ----------------------------------------------------------------------------
package ashs_pkg;

    // default parameter values
    localparam int DEF_TANH_TABLE_DEPTH = 256;
    localparam int DEF_SAMPLE_BITS      = 24;

    // configuration register map
    localparam logic [2:0] CFG_INPUT_GAIN  = 3'd0;
    localparam logic [2:0] CFG_DRIVE       = 3'd1;
    localparam logic [2:0] CFG_GAIN_COMP   = 3'd2;
    localparam logic [2:0] CFG_OUTPUT_GAIN = 3'd3;
    localparam logic [2:0] CFG_BYPASS      = 3'd4;
    localparam logic [2:0] CFG_HARD_MODE   = 3'd5;

    // register reset values
    localparam logic [15:0] RST_INPUT_GAIN  = 16'd8192;
    localparam logic [15:0] RST_DRIVE       = 16'd2048;
    localparam logic [15:0] RST_GAIN_COMP   = 16'd32768;
    localparam logic [15:0] RST_OUTPUT_GAIN = 16'd8192;

    // ceil(2^32 / 5): floor(n/5) = (n * RECIP5) >> 32 for n < 2^30
    localparam logic [29:0] RECIP5 = 30'd858993460;

    // (a*b) >> 60, truncating
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        pr = {64'b0, a} * {64'b0, b};
        return pr[123:60];
    endfunction

endpackage

// File: src/audio_soft_hard_saturator_unit.sv
// ----------------------------------------------------------------------------
// audio_soft_hard_saturator_unit
// Per-sample waveshaper: input gain, drive, tanh soft curve or hard blend
// with a rational term, gain compensation, output gain, SAMPLE_BITS-bit saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel (tdata holds sample_in) and leave on
//   m_axis (tdata holds sample_out, tuser holds the clipped flag), one result
//   per sample, in order. Registers are written through the cfg channel
//   (index plus 16-bit data, always ready); the user writes them only while
//   no sample is in flight, which the block does not enforce. Throughput is
//   one sample per clock while the skid register is empty. The datapath is a
//   35-stage pipeline, whose first stage loads at the transfer itself and
//   whose length is set by the restoring divider for the rational term (one
//   quotient bit per stage, 25 stages), then the output register.
//   The tanh table is a ROM with two registered read ports.
//   Reset clears all valid bits and returns the registers to unity gains,
//   soft mode, bypass off. When the receiver stalls, results collect in the
//   output register and one skid register; s_axis_tready drops only when
//   the skid register is full, and the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module audio_soft_hard_saturator_unit #(
    parameter int TANH_TABLE_DEPTH = ashs_pkg::DEF_TANH_TABLE_DEPTH,
    parameter int SAMPLE_BITS      = ashs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample_in
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,  // sample_out
    output logic                                   m_axis_tuser,  // clipped
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [2:0]                             i_cfg_index,
    input  logic [15:0]                            i_cfg_data
);
    import ashs_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int TDB   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int VB    = SB + 2;
    localparam int HSB   = (SB > 24) ? SB + 2 : 26;
    localparam int ZB    = (SB + 5 > 29) ? SB + 5 : 29;
    localparam int IDXB  = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int PB    = 26 + IDXB;
    localparam int SH_DN = (SB > 24) ? SB - 24 : 0;
    localparam int SH_UP = (SB < 24) ? 24 - SB : 0;

    // stage map
    localparam int ST_MAG = 0;
    localparam int ST_V   = 1;
    localparam int ST_V23 = 2;
    localparam int ST_U   = 3;
    localparam int ST_N   = 4;
    localparam int ST_W   = 5;
    localparam int ST_P   = 6;
    localparam int ST_ROM = 7;
    localparam int ST_T   = ST_ROM + 1;
    localparam int QBITS  = 25;
    localparam int ST_DV0 = ST_N + 1;
    localparam int ST_DVN = ST_N + QBITS;
    localparam int ST_H0  = ST_DVN + 1;
    localparam int ST_H1  = ST_H0 + 1;
    localparam int ST_H2  = ST_H1 + 1;
    localparam int ST_Z   = ST_H2 + 1;
    localparam int ST_OUT = ST_Z + 1;
    localparam int NST    = ST_OUT + 1;

    typedef logic [23:0] t_rom [0:TANH_TABLE_DEPTH];

    typedef struct packed {
        logic            neg;
        logic [SB-1:0]   mag;
        logic [VB-1:0]   v;
        logic [26:0]     v23;
        logic [ZB-1:0]   zb;
        logic [31:0]     u;
        logic [28:0]     n;
        logic            sat;
        logic [25:0]     w;
        logic [IDXB-1:0] idx;
        logic [25:0]     frac;
        logic [23:0]     t;
        logic [32:0]     rem;
        logic [24:0]     dlo;
        logic [32:0]     den;
        logic [24:0]     q;
        logic [24:0]     h;
        logic [25:0]     hg;
        logic [HSB-1:0]  hs;
        logic [ZB-1:0]   z;
        logic            clip;
        logic [SB-1:0]   y;
    } t_stage;

    // long division for table elaboration only, shift and subtract
    function automatic logic [63:0] f_udiv(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(8k/DEPTH) points in Q.23, made non-decreasing
    function automatic t_rom f_build_rom();
        logic [63:0] y;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] t;
        t_rom        tab;
        y    = f_udiv(64'h8000_0000_0000_0000, 64'(TANH_TABLE_DEPTH)) << 1;
        r    = 64'h1000_0000_0000_0000;
        term = 64'h1000_0000_0000_0000;
        e    = 64'h1000_0000_0000_0000;
        for (int n = 1; n <= 40; n++) begin
            term = f_udiv(mul_q60(term, y), 64'(n));
            if (n[0] == 1'b1) r = r - term;
            else r = r + term;
        end
        for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
            num = (64'h1000_0000_0000_0000 - e) >> 20;
            den = (64'h1000_0000_0000_0000 + e) >> 20;
            t   = f_udiv((num << 23) + (den >> 1), den);
            if (k > 0) begin
                if (t < {40'b0, tab[k-1]}) t = {40'b0, tab[k-1]};
            end
            tab[k] = t[23:0];
            e = mul_q60(e, r);
        end
        return tab;
    endfunction

    localparam t_rom TANH_ROM = f_build_rom();

    // configuration registers
    logic [15:0] r_input_gain;
    logic [15:0] r_drive;
    logic [15:0] r_gain_comp;
    logic [15:0] r_output_gain;
    logic        r_bypass;
    logic        r_hard_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain  <= RST_INPUT_GAIN;
            r_drive       <= RST_DRIVE;
            r_gain_comp   <= RST_GAIN_COMP;
            r_output_gain <= RST_OUTPUT_GAIN;
            r_bypass      <= 1'b0;
            r_hard_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INPUT_GAIN:  r_input_gain  <= i_cfg_data;
                CFG_DRIVE:       r_drive       <= i_cfg_data;
                CFG_GAIN_COMP:   r_gain_comp   <= i_cfg_data;
                CFG_OUTPUT_GAIN: r_output_gain <= i_cfg_data;
                CFG_BYPASS:      r_bypass      <= i_cfg_data[0];
                CFG_HARD_MODE:   r_hard_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline
    logic           en;
    logic [NST-1:0] r_vld;
    t_stage         r_p [NST];
    t_stage         n_p [NST];
    logic [23:0]    r_ra;
    logic [23:0]    r_rb;

    // stage 0: sign and magnitude
    always_comb begin
        logic [SB-1:0] raw;
        raw      = s_axis_tdata[SB-1:0];
        n_p[ST_MAG]     = '0;
        n_p[ST_MAG].neg = raw[SB-1];
        n_p[ST_MAG].mag = raw[SB-1] ? (~raw + 1'b1) : raw;
    end

    for (genvar gi = 1; gi < NST; gi++) begin : g_st
        always_comb begin
            logic [SB+15:0]  pg;
            logic [VB+15:0]  pb;
            logic [42:0]     pu;
            logic [34:0]     n3;
            logic [34:0]     n6;
            logic [57:0]     dd;
            logic [58:0]     pm;
            logic [PB-1:0]   pp;
            logic [23:0]     diff;
            logic [49:0]     pf;
            logic [28:0]     s5;
            logic [40:0]     ph;
            logic [HSB+15:0] pz;
            logic [33:0]     rr;
            logic [ZB-1:0]   lim;
            n_p[gi] = r_p[gi-1];
            pg = '0; pb = '0; pu = '0; n3 = '0; n6 = '0; dd = '0; pm = '0; pp = '0;
            diff = '0; pf = '0; s5 = '0; ph = '0; pz = '0; rr = '0; lim = '0;

            // input gain
            if (gi == ST_V) begin
                pg = (SB+16)'(r_p[gi-1].mag) * (SB+16)'(r_input_gain);
                n_p[gi].v = VB'((pg + (SB+16)'(4096)) >> 13);
            end

            // bypass result and alignment to Q.23
            if (gi == ST_V23) begin
                pb = (VB+16)'(r_p[gi-1].v) * (VB+16)'(r_output_gain);
                n_p[gi].zb = ZB'((pb + (VB+16)'(4096)) >> 13);
                if (SB > 24) begin
                    n_p[gi].v23 = 27'((r_p[gi-1].v + VB'(1 << (SH_DN - 1))) >> SH_DN);
                end else begin
                    n_p[gi].v23 = 27'(r_p[gi-1].v) << SH_UP;
                end
            end

            // drive
            if (gi == ST_U) begin
                pu = 43'(r_p[gi-1].v23) * 43'(r_drive);
                n_p[gi].u = 32'((pu + 43'd1024) >> 11);
            end

            // table argument numerator, divider setup
            if (gi == ST_N) begin
                n3 = {3'b0, r_p[gi-1].u} + {2'b0, r_p[gi-1].u, 1'b0} + 35'd2;
                n6 = {2'b0, r_p[gi-1].u, 1'b0} + {1'b0, r_p[gi-1].u, 2'b0} + 35'd2;
                if (r_hard_mode) begin
                    n_p[gi].n   = n6[28:0];
                    n_p[gi].sat = (n6 >= 35'd335544320);
                end else begin
                    n_p[gi].n   = n3[28:0];
                    n_p[gi].sat = (n3 >= 35'd268435456);
                end
                n_p[gi].den = {1'b0, r_p[gi-1].u} + 33'd33554432;
                dd = {1'b0, r_p[gi-1].u, 25'b0} + 58'(n_p[gi].den >> 1);
                n_p[gi].rem = dd[57:25];
                n_p[gi].dlo = dd[24:0];
                n_p[gi].q   = '0;
            end

            // table argument
            if (gi == ST_W) begin
                if (r_hard_mode) begin
                    pm = 59'(r_p[gi-1].n) * 59'(RECIP5);
                    n_p[gi].w = pm[57:32];
                end else begin
                    n_p[gi].w = r_p[gi-1].n[27:2];
                end
            end

            // table index and fraction
            if (gi == ST_P) begin
                pp = PB'(r_p[gi-1].w) * PB'(TANH_TABLE_DEPTH);
                n_p[gi].idx  = pp[PB-1:26];
                n_p[gi].frac = pp[25:0];
            end

            // interpolation
            if (gi == ST_T) begin
                diff = r_rb - r_ra;
                pf = 50'(diff) * 50'(r_p[gi-1].frac);
                n_p[gi].t = r_p[gi-1].sat ? 24'h80_0000
                                          : r_ra + 24'((pf + 50'h200_0000) >> 26);
            end

            // restoring divider, one quotient bit per stage
            if (gi >= ST_DV0 && gi <= ST_DVN) begin
                rr = {r_p[gi-1].rem, r_p[gi-1].dlo[24]};
                n_p[gi].dlo = {r_p[gi-1].dlo[23:0], 1'b0};
                if (rr >= {1'b0, r_p[gi-1].den}) begin
                    n_p[gi].rem = 33'(rr - {1'b0, r_p[gi-1].den});
                    n_p[gi].q   = {r_p[gi-1].q[23:0], 1'b1};
                end else begin
                    n_p[gi].rem = rr[32:0];
                    n_p[gi].q   = {r_p[gi-1].q[23:0], 1'b0};
                end
            end

            // curve blend
            if (gi == ST_H0) begin
                if (r_hard_mode) begin
                    s5 = 29'(r_p[gi-1].t) + {4'b0, r_p[gi-1].t, 1'b0}
                       + {3'b0, r_p[gi-1].q, 1'b0} + 29'd2;
                    pm = 59'(s5) * 59'(RECIP5);
                    n_p[gi].h = pm[56:32];
                end else begin
                    n_p[gi].h = {1'b0, r_p[gi-1].t};
                end
            end

            // gain compensation
            if (gi == ST_H1) begin
                ph = 41'(r_p[gi-1].h) * 41'(r_gain_comp);
                n_p[gi].hg = 26'((ph + 41'd16384) >> 15);
            end

            // back to sample format
            if (gi == ST_H2) begin
                if (SB > 24) begin
                    n_p[gi].hs = HSB'(r_p[gi-1].hg) << SH_DN;
                end else if (SB < 24) begin
                    n_p[gi].hs = HSB'((r_p[gi-1].hg + 26'(1 << (SH_UP - 1))) >> SH_UP);
                end else begin
                    n_p[gi].hs = HSB'(r_p[gi-1].hg);
                end
            end

            // output gain
            if (gi == ST_Z) begin
                if (r_bypass) begin
                    n_p[gi].z = r_p[gi-1].zb;
                end else begin
                    pz = (HSB+16)'(r_p[gi-1].hs) * (HSB+16)'(r_output_gain);
                    n_p[gi].z = ZB'((pz + (HSB+16)'(4096)) >> 13);
                end
            end

            // saturation and sign
            if (gi == ST_OUT) begin
                lim = r_p[gi-1].neg ? (ZB'(1) << (SB - 1)) : ((ZB'(1) << (SB - 1)) - 1'b1);
                if (r_p[gi-1].z > lim) begin
                    n_p[gi].clip = 1'b1;
                    n_p[gi].y    = r_p[gi-1].neg ? SB'(~lim + 1'b1) : lim[SB-1:0];
                end else begin
                    n_p[gi].clip = 1'b0;
                    n_p[gi].y    = r_p[gi-1].neg ? SB'(~r_p[gi-1].z + 1'b1)
                                                 : r_p[gi-1].z[SB-1:0];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // stage payload and table read
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_p[k] <= n_p[k];
            end
            r_ra <= TANH_ROM[r_p[ST_P].idx];
            r_rb <= TANH_ROM[IDXB'(r_p[ST_P].idx + 1'b1)];
        end
    end

    // output register and skid stage
    logic          r_out_vld;
    logic          r_skid_vld;
    logic [SB-1:0] r_out_y;
    logic          r_out_clip;
    logic [SB-1:0] r_skid_y;
    logic          r_skid_clip;
    logic          n_out_vld;
    logic          n_skid_vld;
    logic          out_load;
    logic          out_from_skid;
    logic          skid_load;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    always_comb begin
        n_out_vld     = r_out_vld;
        n_skid_vld    = r_skid_vld;
        out_load      = 1'b0;
        out_from_skid = 1'b0;
        skid_load     = 1'b0;
        if (r_skid_vld) begin
            if (m_axis_tready) begin
                out_load      = 1'b1;
                out_from_skid = 1'b1;
                n_skid_vld    = 1'b0;
            end
        end else if (!r_out_vld || m_axis_tready) begin
            out_load  = 1'b1;
            n_out_vld = r_vld[NST-1];
        end else if (r_vld[NST-1]) begin
            skid_load  = 1'b1;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_y    <= out_from_skid ? r_skid_y : r_p[NST-1].y;
            r_out_clip <= out_from_skid ? r_skid_clip : r_p[NST-1].clip;
        end
        if (skid_load) begin
            r_skid_y    <= r_p[NST-1].y;
            r_skid_clip <= r_p[NST-1].clip;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDB'(r_out_y);
    assign m_axis_tuser  = r_out_clip;

endmodule
